// ===== hw/rtl/intermittent_output_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// intermittent output sequencer assertion macros
// concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef INTERMITTENT_OUTPUT_SEQUENCER_ASSERT_SVH
`define INTERMITTENT_OUTPUT_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define IOS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("intermittent output sequencer assertion failed");
// checked property, also active during reset
`define IOS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("intermittent output sequencer assertion failed");
`else
`define IOS_ASSERT(label, clk, rst_n, prop)
`define IOS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/ios_pkg.sv =====
// ----------------------------------------------------------------------------
// ios_pkg
// shared types and constants of the intermittent output sequencer
// ----------------------------------------------------------------------------
package ios_pkg;

  localparam int unsigned TickW  = 20;
  localparam int unsigned CountW = 16;
  localparam int unsigned PeriodW = TickW + 1;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [TickW-1:0]  ElapsedCap = 20'd600000;
  localparam logic [CountW-1:0] CycleMax   = 16'hFFFF;

  localparam logic [CfgIdxW-1:0] RegOnTicks     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOffTicks    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRepeatLimit = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRepeatEn    = 2'd3;

  typedef struct packed {
    logic [TickW-1:0]  on_ticks;
    logic [TickW-1:0]  off_ticks;
    logic [CountW-1:0] repeat_limit;
    logic              repeat_enable;
  } cfg_t;

  typedef struct packed {
    logic [TickW-1:0]  elapsed;
    logic [CountW-1:0] cycles;
    logic              level;
  } state_t;

endpackage

// ===== hw/rtl/ios_cfg.sv =====
// ----------------------------------------------------------------------------
// ios_cfg
// configuration register file of the intermittent output sequencer
// ----------------------------------------------------------------------------
module ios_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ios_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ios_pkg::CfgDataW-1:0]  cfg_data_i,
  output ios_pkg::cfg_t                 cfg_o
);
  import ios_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegOnTicks:     cfg_d.on_ticks      = cfg_data_i[TickW-1:0];
        RegOffTicks:    cfg_d.off_ticks     = cfg_data_i[TickW-1:0];
        RegRepeatLimit: cfg_d.repeat_limit  = cfg_data_i[CountW-1:0];
        RegRepeatEn:    cfg_d.repeat_enable = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/ios_core.sv =====
// ----------------------------------------------------------------------------
// ios_core
// channel state registers and single-tick update logic
// ----------------------------------------------------------------------------
module ios_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ios_pkg::cfg_t   cfg_i,
  input  logic            step_i,
  input  logic            condition_i,
  output ios_pkg::state_t state_d_o,
  output ios_pkg::state_t state_q_o
);
  import ios_pkg::*;

  state_t state_q, state_d;

  logic [PeriodW-1:0] period;
  logic               below_limit;
  logic               running;
  logic [TickW-1:0]   elapsed_adv;
  logic [TickW-1:0]   elapsed_1;
  logic [CountW-1:0]  cycles_1;

  assign period = {1'b0, cfg_i.on_ticks} + {1'b0, cfg_i.off_ticks};
  assign below_limit = (cfg_i.repeat_limit == '0) ||
                       (state_q.cycles < cfg_i.repeat_limit);
  assign elapsed_adv = (state_q.elapsed >= ElapsedCap) ? ElapsedCap
                                                       : state_q.elapsed + 1'b1;
  assign running = (condition_i && below_limit) ||
                   ((state_q.elapsed != '0) && ({1'b0, state_q.elapsed} < period)) ||
                   ((state_q.cycles != '0) && (state_q.cycles < cfg_i.repeat_limit));
  assign elapsed_1 = running ? elapsed_adv : '0;
  assign cycles_1  = (!running && !condition_i) ? '0 : state_q.cycles;

  always_comb begin
    state_d = state_q;
    if (step_i && (cfg_i.on_ticks != '0)) begin
      state_d.elapsed = elapsed_1;
      state_d.cycles  = cycles_1;
      state_d.level   = 1'b0;
      if ((elapsed_1 != '0) && (elapsed_1 < cfg_i.on_ticks)) begin
        state_d.level = 1'b1;
      end else if (cfg_i.repeat_enable && ({1'b0, elapsed_1} >= period)) begin
        // end of on+off period restarts the count
        state_d.elapsed = '0;
        if (cycles_1 != CycleMax) begin
          state_d.cycles = cycles_1 + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_d_o = state_d;
  assign state_q_o = state_q;

endmodule

// ===== hw/rtl/intermittent_output_sequencer.sv =====
// ----------------------------------------------------------------------------
// intermittent_output_sequencer
// one-channel on/off pulse sequencer advanced once per input transfer
// result registered, valid in the cycle after the input transfer
// throughput: one transfer per cycle while the result register is not stalled
// a stalled result register blocks new input only while it is full
// reset: asynchronous, clears configuration, channel state and result valid
// ----------------------------------------------------------------------------
`include "intermittent_output_sequencer_assert.svh"

module intermittent_output_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ios_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ios_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          condition_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          output_on_o,
  output logic [ios_pkg::CountW-1:0]    cycles_completed_o
);
  import ios_pkg::*;

  cfg_t   cfg;
  state_t state_d;
  state_t state_q;
  logic   in_xfer;

  logic              out_valid_q, out_valid_d;
  logic              output_on_q;
  logic [CountW-1:0] cycles_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  ios_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ios_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (in_xfer),
    .condition_i (condition_i),
    .state_d_o   (state_d),
    .state_q_o   (state_q)
  );

  assign out_valid_d = in_xfer || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      output_on_q <= state_d.level;
      cycles_q    <= state_d.cycles;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign output_on_o        = output_on_q;
  assign cycles_completed_o = cycles_q;

  `IOS_ASSERT(a_xfer_gives_result, clk_i, rst_ni, in_xfer |=> out_valid_o)
  `IOS_ASSERT(a_idle_holds_state, clk_i, rst_ni, !in_xfer |=> $stable(state_q))
  `IOS_ASSERT(a_elapsed_capped, clk_i, rst_ni, state_q.elapsed <= ElapsedCap)
  `IOS_ASSERT(a_level_needs_count, clk_i, rst_ni, !state_q.level || (state_q.elapsed != '0))

endmodule
